FILE: rtl/periodic_task_dispatch_table_core_defines.svh
// assertion macros shared by the task dispatch table checker
// no dependencies
`ifndef PERIODIC_TASK_DISPATCH_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TASK_DISPATCH_TABLE_CORE_DEFINES_SVH

// check that is switched off while reset is high
`define PTD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("ptd check failed");

// check that also runs through reset
`define PTD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("ptd check failed");

`endif

FILE: rtl/ptd_pkg.sv
// types and constants for the periodic task dispatch table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ptd_pkg;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_ADD    = 3'd1,
      OP_PAUSE  = 3'd2,
      OP_RESUME = 3'd3,
      OP_MODIFY = 3'd4,
      OP_REMOVE = 3'd5,
      OP_QUERY  = 3'd6,
      OP_CLEAR  = 3'd7
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_EV,
      ST_FLUSH,
      ST_ADD,
      ST_CLEAR,
      ST_FIND_RD,
      ST_FIND_EV,
      ST_NOT_FOUND,
      ST_SHIFT_RD,
      ST_SHIFT_EV,
      ST_REM_DONE
   } state_type;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INTERVAL     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_INTERVAL = 1'd1;

   localparam logic [30:0] MAX_INTERVAL_RESET     = 31'h7FFF_FFFF;
   localparam logic [30:0] DEFAULT_INTERVAL_RESET = 31'd50;

   localparam logic [1:0] STAT_PAUSED   = 2'd0;
   localparam logic [1:0] STAT_PERIODIC = 2'd1;
   localparam logic [1:0] STAT_ONESHOT  = 2'd2;
   localparam logic [1:0] STAT_INVALID  = 2'd3;

   localparam logic KIND_ACK      = 1'b0;
   localparam logic KIND_DISPATCH = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rd_next;
      logic ev_tick;
      logic ev_find;
      logic ev_shift;
      logic do_add;
      logic do_clear;
      logic ack_fail;
      logic rem_done;
      logic flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;
      logic shift_end;
      logic match;
      logic is_remove;
   } stat_type;

endpackage
`default_nettype wire

FILE: rtl/ptd_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ptd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

FILE: rtl/ptd_ctrl.sv
// controller state machine for the task dispatch table
// depends on ptd_pkg
`timescale 1ns / 1ps
`default_nettype none
module ptd_ctrl (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [2:0] req_opcode,
   input  ptd_pkg::stat_type stat,
   output ptd_pkg::cmd_type  cmd,
   output logic            busy
);

   ptd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (start) begin
               unique case (ptd_pkg::opcode_type'(req_opcode))
                  ptd_pkg::OP_TICK:  state_in = ptd_pkg::ST_TICK_RD;
                  ptd_pkg::OP_ADD:   state_in = ptd_pkg::ST_ADD;
                  ptd_pkg::OP_CLEAR: state_in = ptd_pkg::ST_CLEAR;
                  default:           state_in = ptd_pkg::ST_FIND_RD;
               endcase
            end
         end
         ptd_pkg::ST_TICK_RD: begin
            state_in = stat.scan_end ? ptd_pkg::ST_FLUSH : ptd_pkg::ST_TICK_EV;
         end
         ptd_pkg::ST_TICK_EV: state_in = ptd_pkg::ST_TICK_RD;
         ptd_pkg::ST_FIND_RD: begin
            state_in = stat.scan_end ? ptd_pkg::ST_NOT_FOUND : ptd_pkg::ST_FIND_EV;
         end
         ptd_pkg::ST_FIND_EV: begin
            priority if (stat.match && stat.is_remove) begin
               state_in = ptd_pkg::ST_SHIFT_RD;
            end else if (stat.match) begin
               state_in = ptd_pkg::ST_IDLE;
            end else begin
               state_in = ptd_pkg::ST_FIND_RD;
            end
         end
         ptd_pkg::ST_SHIFT_RD: begin
            state_in = stat.shift_end ? ptd_pkg::ST_REM_DONE : ptd_pkg::ST_SHIFT_EV;
         end
         ptd_pkg::ST_SHIFT_EV: state_in = ptd_pkg::ST_SHIFT_RD;
         default: state_in = ptd_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      busy = (state_ff != ptd_pkg::ST_IDLE);
      unique case (state_ff)
         ptd_pkg::ST_IDLE:      cmd.load = start;
         ptd_pkg::ST_TICK_EV:   cmd.ev_tick = 1'b1;
         ptd_pkg::ST_FLUSH:     cmd.flush = 1'b1;
         ptd_pkg::ST_ADD:       cmd.do_add = 1'b1;
         ptd_pkg::ST_CLEAR:     cmd.do_clear = 1'b1;
         ptd_pkg::ST_FIND_EV:   cmd.ev_find = 1'b1;
         ptd_pkg::ST_NOT_FOUND: cmd.ack_fail = 1'b1;
         ptd_pkg::ST_SHIFT_RD:  cmd.rd_next = 1'b1;
         ptd_pkg::ST_SHIFT_EV:  cmd.ev_shift = 1'b1;
         ptd_pkg::ST_REM_DONE:  cmd.rem_done = 1'b1;
         default:               cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/ptd_datapath.sv
// datapath of the task dispatch table: counters, entry ram, results
// depends on ptd_pkg and ptd_ram
`timescale 1ns / 1ps
`default_nettype none
module ptd_datapath #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_WIDTH   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  ptd_pkg::cmd_type cmd,
   output ptd_pkg::stat_type stat,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_task_key,
   input  wire logic [31:0] req_interval,
   input  wire logic [2:0]  req_start_mode,
   input  wire logic        csr_valid,
   input  wire logic [ptd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0] csr_data,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic [15:0]      rsp_task_key_res,
   output logic             rsp_ok,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = KEY_WIDTH + 66;

   logic [2:0]           op_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [31:0]          ival_ff;
   logic [2:0]           mode_ff;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [31:0]          tick_ff, tick_in;
   logic [30:0]          max_ff, def_ff;
   logic                 pend_ff, pend_in;
   logic [KEY_WIDTH-1:0] pend_key_ff, pend_key_in;
   logic [1:0]           pend_st_ff, pend_st_in;

   logic                 rv_in, rkind_in, rok_in, rlast_in;
   logic [15:0]          rkey_in;
   logic [1:0]           rst_in;

   logic                 we;
   logic [AW-1:0]        waddr, raddr;
   logic [EW-1:0]        wdata, rdata;

   logic [KEY_WIDTH-1:0] e_key;
   logic [1:0]           e_st;
   logic [31:0]          e_iv, e_due, diff;
   logic [CW-1:0]        idx_inc;
   logic                 due_now, full, iv_bad;
   logic [1:0]           add_st;
   logic [31:0]          add_iv;

   assign {e_key, e_st, e_iv, e_due} = rdata;
   assign idx_inc = idx_ff + CW'(1);
   assign diff    = tick_ff - e_due;
   assign due_now = (e_st != ptd_pkg::STAT_PAUSED) && !diff[31];
   assign full    = (cnt_ff == CW'(MAX_ENTRIES));
   assign iv_bad  = (ival_ff == 32'd0) || (ival_ff > {1'b0, max_ff});
   assign add_st  = (mode_ff[1:0] == ptd_pkg::STAT_INVALID) ? ptd_pkg::STAT_PERIODIC
                                                            : mode_ff[1:0];
   assign add_iv  = iv_bad ? {1'b0, def_ff} : ival_ff;
   assign raddr   = cmd.rd_next ? idx_inc[AW-1:0] : idx_ff[AW-1:0];

   assign stat.scan_end  = (idx_ff == cnt_ff);
   assign stat.shift_end = (idx_inc == cnt_ff);
   assign stat.match     = (e_key == key_ff);
   assign stat.is_remove = (op_ff == ptd_pkg::OP_REMOVE);

   ptd_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_ENTRIES)
   ) u_ram (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   // per-command updates
   always_comb begin
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      tick_in     = tick_ff;
      pend_in     = pend_ff;
      pend_key_in = pend_key_ff;
      pend_st_in  = pend_st_ff;
      we          = 1'b0;
      waddr       = idx_ff[AW-1:0];
      wdata       = rdata;
      rv_in       = 1'b0;
      rkind_in    = ptd_pkg::KIND_ACK;
      rkey_in     = 16'(key_ff);
      rok_in      = 1'b0;
      rst_in      = ptd_pkg::STAT_PAUSED;
      rlast_in    = 1'b1;

      if (cmd.load) begin
         idx_in  = '0;
         pend_in = 1'b0;
         if (req_opcode == ptd_pkg::OP_TICK) begin
            tick_in = tick_ff + 32'd1;
         end
      end

      // tick scan: write back fired entries, hold one dispatch back for last
      if (cmd.ev_tick) begin
         idx_in = idx_inc;
         if (due_now) begin
            we = 1'b1;
            if (e_st == ptd_pkg::STAT_ONESHOT) begin
               wdata = {e_key, ptd_pkg::STAT_PAUSED, e_iv, e_due};
            end else begin
               wdata = {e_key, e_st, e_iv, tick_ff + e_iv};
            end
            if (pend_ff) begin
               rv_in    = 1'b1;
               rkind_in = ptd_pkg::KIND_DISPATCH;
               rkey_in  = 16'(pend_key_ff);
               rok_in   = 1'b1;
               rst_in   = pend_st_ff;
               rlast_in = 1'b0;
            end
            pend_in     = 1'b1;
            pend_key_in = e_key;
            pend_st_in  = e_st;
         end
      end

      if (cmd.flush && pend_ff) begin
         rv_in    = 1'b1;
         rkind_in = ptd_pkg::KIND_DISPATCH;
         rkey_in  = 16'(pend_key_ff);
         rok_in   = 1'b1;
         rst_in   = pend_st_ff;
      end

      if (cmd.do_add) begin
         rv_in = 1'b1;
         if (!full) begin
            we     = 1'b1;
            waddr  = cnt_ff[AW-1:0];
            wdata  = {key_ff, add_st, add_iv, tick_ff + (mode_ff[2] ? 32'd0 : add_iv)};
            cnt_in = cnt_ff + CW'(1);
            rok_in = 1'b1;
         end
      end

      if (cmd.do_clear) begin
         rv_in  = 1'b1;
         rok_in = 1'b1;
         cnt_in = '0;
      end

      if (cmd.ack_fail) begin
         rv_in = 1'b1;
      end

      // search step: act on the first matching entry
      if (cmd.ev_find) begin
         if (!stat.match) begin
            idx_in = idx_inc;
         end else if (!stat.is_remove) begin
            rv_in  = 1'b1;
            rok_in = 1'b1;
            unique case (ptd_pkg::opcode_type'(op_ff))
               ptd_pkg::OP_PAUSE: begin
                  we    = 1'b1;
                  wdata = {e_key, ptd_pkg::STAT_PAUSED, e_iv, e_due};
               end
               ptd_pkg::OP_RESUME: begin
                  we    = 1'b1;
                  wdata = {e_key, ptd_pkg::STAT_PERIODIC, e_iv, tick_ff + e_iv};
               end
               ptd_pkg::OP_MODIFY: begin
                  we = 1'b1;
                  if (mode_ff == {1'b0, ptd_pkg::STAT_PERIODIC} ||
                      mode_ff == {1'b0, ptd_pkg::STAT_ONESHOT}) begin
                     wdata = {e_key, mode_ff[1:0], ival_ff, tick_ff + ival_ff};
                  end else begin
                     wdata = {e_key, e_st, ival_ff, tick_ff + ival_ff};
                  end
               end
               ptd_pkg::OP_QUERY: rst_in = e_st;
               default: rst_in = ptd_pkg::STAT_PAUSED;
            endcase
         end
      end

      // remove: move the next entry down one place
      if (cmd.ev_shift) begin
         we     = 1'b1;
         wdata  = rdata;
         idx_in = idx_inc;
      end

      if (cmd.rem_done) begin
         rv_in  = 1'b1;
         rok_in = 1'b1;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         tick_ff   <= '0;
         pend_ff   <= 1'b0;
         rsp_valid <= 1'b0;
         max_ff    <= ptd_pkg::MAX_INTERVAL_RESET;
         def_ff    <= ptd_pkg::DEFAULT_INTERVAL_RESET;
      end else begin
         cnt_ff    <= cnt_in;
         tick_ff   <= tick_in;
         pend_ff   <= pend_in;
         rsp_valid <= rv_in;
         if (csr_valid && csr_index == ptd_pkg::CSR_MAX_INTERVAL) begin
            max_ff <= csr_data[30:0];
         end
         if (csr_valid && csr_index == ptd_pkg::CSR_DEFAULT_INTERVAL) begin
            def_ff <= csr_data[30:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         key_ff  <= KEY_WIDTH'(req_task_key);
         ival_ff <= req_interval;
         mode_ff <= req_start_mode;
      end
      idx_ff           <= idx_in;
      pend_key_ff      <= pend_key_in;
      pend_st_ff       <= pend_st_in;
      rsp_kind         <= rkind_in;
      rsp_task_key_res <= rkey_in;
      rsp_ok           <= rok_in;
      rsp_status       <= rst_in;
      rsp_last         <= rlast_in;
   end

endmodule
`default_nettype wire

FILE: rtl/periodic_task_dispatch_table_core.sv
// a tick reads then evaluates each held entry in turn, then flushes the held dispatch;
// a search reads and evaluates entries up to the first match; one operation at a time,
// a new start being taken only in the idle state, once the last one is done
// dispatches of a tick come out one per scanned due entry, the last flagged
// sync reset empties the table, zeroes the tick counter and reloads the registers
// depends on ptd_pkg, ptd_ctrl, ptd_datapath
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_dispatch_table_core #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_WIDTH   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_task_key,
   input  wire logic [31:0] req_interval,
   input  wire logic [2:0]  req_start_mode,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic [15:0]      rsp_task_key_res,
   output logic             rsp_ok,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [ptd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0] csr_data
);

   ptd_pkg::cmd_type  cmd;
   ptd_pkg::stat_type stat;

   // registers are always writable
   assign csr_ready = 1'b1;

   ptd_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_opcode(req_opcode),
      .stat(stat),
      .cmd(cmd),
      .busy(busy)
   );

   ptd_datapath #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .KEY_WIDTH(KEY_WIDTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_opcode(req_opcode),
      .req_task_key(req_task_key),
      .req_interval(req_interval),
      .req_start_mode(req_start_mode),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind),
      .rsp_task_key_res(rsp_task_key_res),
      .rsp_ok(rsp_ok),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

endmodule
`default_nettype wire

FILE: rtl/ptd_checker.sv
// port-level checks for the task dispatch table, bound to the top level
// depends on ptd_pkg and periodic_task_dispatch_table_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_dispatch_table_core_defines.svh"
module ptd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic       rsp_kind,
   input wire logic       rsp_ok,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last
);

   // an accepted transaction makes the block busy in the cycle after it
   `PTD_ASSERT(a_busy_after_start, clock, reset, (start && !busy) |=> busy)
   // acknowledges are single results
   `PTD_ASSERT(a_ack_is_last, clock, reset, (rsp_valid && !rsp_kind) |-> rsp_last)
   // dispatches only come from active tasks
   `PTD_ASSERT(a_dispatch_active, clock, reset,
      (rsp_valid && rsp_kind) |-> (rsp_ok && (rsp_status == ptd_pkg::STAT_PERIODIC ||
      rsp_status == ptd_pkg::STAT_ONESHOT)))
   // reset leaves the block idle and silent
   `PTD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid))

endmodule

bind periodic_task_dispatch_table_core ptd_checker u_ptd_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_kind(rsp_kind),
   .rsp_ok(rsp_ok),
   .rsp_status(rsp_status),
   .rsp_last(rsp_last)
);
`default_nettype wire
